/* src/mhfb_pkg.sv */
// Package for the multicast hash filter builder.
// Holds the request and response payload types, register indexes and CRC constants.
// No dependencies.
package mhfb_pkg;

   localparam int unsigned MAC_WIDTH        = 48;
   localparam int unsigned WORD_WIDTH       = 32;
   localparam int unsigned TABLE_WIDTH      = 64;
   localparam int unsigned HASH_INDEX_WIDTH = 6;
   localparam int unsigned CRC_WIDTH        = 32;
   localparam int unsigned CSR_INDEX_WIDTH  = 1;
   localparam int unsigned CSR_DATA_WIDTH   = 1;

   localparam logic [CRC_WIDTH-1:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [CRC_WIDTH-1:0] CRC_INIT = 32'hFFFF_FFFF;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROMISCUOUS_ENABLE   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALL_MULTICAST_ENABLE = 1'b1;

   typedef struct packed {
      logic [MAC_WIDTH-1:0] mac_address;
      logic                 carries_address;
      logic                 last_address;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] hash_low_word;
      logic [WORD_WIDTH-1:0] hash_high_word;
      logic                  pass_all_multicast;
      logic                  promiscuous_on;
   } rsp_payload_type;

   typedef struct packed {
      logic                        is_multicast;
      logic [HASH_INDEX_WIDTH-1:0] hash_index;
   } hash_result_type;

endpackage

/* src/mhfb_hash.sv */
// Ethernet CRC-32 hash of one MAC address, reduced to a 6-bit filter index.
// Depends on mhfb_pkg.
module mhfb_hash (
   input  logic [mhfb_pkg::MAC_WIDTH-1:0] mac_address,
   output mhfb_pkg::hash_result_type      hash_result
);

   logic [mhfb_pkg::CRC_WIDTH-1:0] crc;
   logic                           feedback;

   // The bytes go in from byte 0 upward, each LSB first, which is simply the
   // address bits in ascending order. The unrolled shifts form an XOR network.
   always_comb begin
      crc      = mhfb_pkg::CRC_INIT;
      feedback = 1'b0;
      for (int i = 0; i < mhfb_pkg::MAC_WIDTH; i++) begin
         feedback = crc[mhfb_pkg::CRC_WIDTH-1] ^ mac_address[i];
         crc      = {crc[mhfb_pkg::CRC_WIDTH-2:0], 1'b0} ^
                    (feedback ? mhfb_pkg::CRC_POLY : '0);
      end
   end

   assign hash_result.is_multicast = mac_address[0];
   assign hash_result.hash_index   =
      crc[mhfb_pkg::CRC_WIDTH-1 -: mhfb_pkg::HASH_INDEX_WIDTH];

endmodule

/* src/multicast_hash_filter_builder_core.sv */
// Multicast hash filter builder, top level.
// Depends on mhfb_pkg and mhfb_hash.
//
// Usage: addresses of one multicast list arrive as requests on the req_
// channel, one 48-bit address per request; a request with carries_address low
// is an empty entry. The request with last_address high closes the list and
// produces one response on the rsp_ channel with the 64-bit filter, split in
// two words, plus the pass-all and promiscuous flags. Other requests give no
// response. When pass_all_multicast is set the filter words read zero and the
// filter is not meant to be written. The csr_ port sets the promiscuous and
// all-multicast modes; change them only while no list is in flight.
// Timing: a request is captured in an input register and folded into the
// filter from there; a last request loads the result register that drives
// the response. One request per cycle is accepted while no last request
// waits on a stalled response; the rate is set by the combinational CRC and
// table update between input and result registers.
// A stalled response holds its register while non-last requests keep flowing;
// a second last request waits in the input register until the response goes.
// Reset (synchronous) clears the modes, the filter, the address count and
// both handshakes; the filter and count also clear after every response.
module multicast_hash_filter_builder_core #(
   parameter int unsigned MAX_HASHED_ADDRESSES = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  mhfb_pkg::req_payload_type               req_payload,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output mhfb_pkg::rsp_payload_type               rsp_payload,
   input  logic                                    csr_write_enable,
   input  logic [mhfb_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [mhfb_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);

   localparam int unsigned CountWidth = $clog2(MAX_HASHED_ADDRESSES + 2);
   localparam logic [CountWidth-1:0] CountLimit = CountWidth'(MAX_HASHED_ADDRESSES + 1);
   localparam logic [CountWidth-1:0] CountMax   = CountWidth'(MAX_HASHED_ADDRESSES);

   logic                                  promiscuous_ff;
   logic                                  all_multicast_ff;
   logic                                  stage_valid_ff, stage_valid_in;
   mhfb_pkg::req_payload_type             stage_payload_ff;
   logic [mhfb_pkg::TABLE_WIDTH-1:0]      hash_table_ff, hash_table_in;
   logic [CountWidth-1:0]                 address_count_ff, address_count_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   mhfb_pkg::rsp_payload_type             rsp_payload_ff, rsp_payload_in;

   mhfb_pkg::hash_result_type             hash_result;
   logic                                  stage_fire;
   logic                                  rsp_load;
   logic [mhfb_pkg::TABLE_WIDTH-1:0]      table_updated;
   logic [CountWidth-1:0]                 count_updated;
   logic                                  pass_all;

   mhfb_hash u_hash (
      .mac_address (stage_payload_ff.mac_address),
      .hash_result (hash_result)
   );

   // A non-last request never needs the response register, so it moves on
   // even while a response is stalled.
   assign stage_fire = stage_valid_ff &&
                       (!stage_payload_ff.last_address || !rsp_valid_ff || rsp_ready);
   assign rsp_load   = stage_fire && stage_payload_ff.last_address;
   assign req_ready  = !stage_valid_ff || stage_fire;

   always_comb begin
      table_updated = hash_table_ff;
      count_updated = address_count_ff;
      if (stage_payload_ff.carries_address) begin
         if (address_count_ff < CountLimit) begin
            count_updated = address_count_ff + CountWidth'(1);
         end
         if (hash_result.is_multicast) begin
            table_updated[hash_result.hash_index] = 1'b1;
         end
      end
      pass_all = promiscuous_ff || all_multicast_ff || (count_updated > CountMax);

      rsp_payload_in.pass_all_multicast = pass_all;
      rsp_payload_in.promiscuous_on     = promiscuous_ff;
      rsp_payload_in.hash_low_word      =
         pass_all ? '0 : table_updated[mhfb_pkg::WORD_WIDTH-1:0];
      rsp_payload_in.hash_high_word     =
         pass_all ? '0 : table_updated[mhfb_pkg::TABLE_WIDTH-1:mhfb_pkg::WORD_WIDTH];

      hash_table_in    = hash_table_ff;
      address_count_in = address_count_ff;
      if (stage_fire) begin
         hash_table_in    = stage_payload_ff.last_address ? '0 : table_updated;
         address_count_in = stage_payload_ff.last_address ? '0 : count_updated;
      end

      stage_valid_in = req_ready ? req_valid : stage_valid_ff;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         promiscuous_ff   <= 1'b0;
         all_multicast_ff <= 1'b0;
         stage_valid_ff   <= 1'b0;
         hash_table_ff    <= '0;
         address_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               mhfb_pkg::CSR_PROMISCUOUS_ENABLE: begin
                  promiscuous_ff <= csr_write_data[0];
               end
               mhfb_pkg::CSR_ALL_MULTICAST_ENABLE: begin
                  all_multicast_ff <= csr_write_data[0];
               end
               default: begin
               end
            endcase
         end
         stage_valid_ff   <= stage_valid_in;
         hash_table_ff    <= hash_table_in;
         address_count_ff <= address_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_payload_ff <= req_payload;
      end
      if (rsp_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The filter and count must be empty right after a response is produced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (hash_table_ff == '0) && (address_count_ff == '0))
      else $error("filter state not cleared after response");

   // The count saturates one above the hashing limit.
   assert property (@(posedge clock) disable iff (reset)
      address_count_ff <= CountLimit)
      else $error("address count beyond saturation");

   // A pass-all response never carries filter bits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.pass_all_multicast |->
         (rsp_payload.hash_low_word == '0) && (rsp_payload.hash_high_word == '0))
      else $error("pass-all response with nonzero filter");

   // Promiscuous mode always implies pass-all.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.promiscuous_on |-> rsp_payload.pass_all_multicast)
      else $error("promiscuous response without pass-all");

   // A stalled response must not be overwritten by a later list.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !rsp_load)
      else $error("response overwritten while stalled");

endmodule

/* verif/mhfb_report_checker.sv */
// Checker for the multicast hash filter builder: predicts each filter report.
// Watches the req_, rsp_ and csr_ ports and compares every response.
// Depends on mhfb_pkg.
module mhfb_report_checker #(
   parameter int unsigned MAX_HASHED_ADDRESSES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  mhfb_pkg::req_payload_type            req_payload,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  mhfb_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_write_enable,
   input  logic [mhfb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mhfb_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int unsigned                          failures,
   output int unsigned                          reports_pending,
   output int unsigned                          reports_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   mhfb_pkg::rsp_payload_type            expected_reports[$];
   logic [mhfb_pkg::TABLE_WIDTH-1:0]     filter_bits;
   int unsigned                          listed_count;
   logic                                 promisc_mode;
   logic                                 allmulti_mode;

   // Ethernet CRC over the six address bytes, byte 0 first and each byte LSB
   // first, which is simply bit 0 up to bit 47 of the address.
   function automatic logic [mhfb_pkg::HASH_INDEX_WIDTH-1:0] filter_slot(
      input logic [mhfb_pkg::MAC_WIDTH-1:0] mac);
      logic [mhfb_pkg::CRC_WIDTH-1:0] crc;
      logic                           feedback;
      crc = mhfb_pkg::CRC_INIT;
      for (int i = 0; i < mhfb_pkg::MAC_WIDTH; i++) begin
         feedback = crc[mhfb_pkg::CRC_WIDTH-1] ^ mac[i];
         crc = {crc[mhfb_pkg::CRC_WIDTH-2:0], 1'b0};
         if (feedback) begin
            crc = crc ^ mhfb_pkg::CRC_POLY;
         end
      end
      return crc[mhfb_pkg::CRC_WIDTH-1 -: mhfb_pkg::HASH_INDEX_WIDTH];
   endfunction

   always @(posedge clock) begin
      mhfb_pkg::rsp_payload_type want;
      logic                      pass_all;
      if (reset) begin
         expected_reports.delete();
         filter_bits     = '0;
         listed_count    = 0;
         promisc_mode    = 1'b0;
         allmulti_mode   = 1'b0;
         failures        = 0;
         reports_checked = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               mhfb_pkg::CSR_PROMISCUOUS_ENABLE:   promisc_mode  = csr_write_data[0];
               mhfb_pkg::CSR_ALL_MULTICAST_ENABLE: allmulti_mode = csr_write_data[0];
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("filter report arrived with none pending: %p", rsp_payload);
               failures++;
            end else begin
               want = expected_reports.pop_front();
               reports_checked++;
               if (rsp_payload.hash_low_word !== want.hash_low_word) begin
                  $error("hash_low_word: expected %h, got %h",
                         want.hash_low_word, rsp_payload.hash_low_word);
                  failures++;
               end
               if (rsp_payload.hash_high_word !== want.hash_high_word) begin
                  $error("hash_high_word: expected %h, got %h",
                         want.hash_high_word, rsp_payload.hash_high_word);
                  failures++;
               end
               if (rsp_payload.pass_all_multicast !== want.pass_all_multicast) begin
                  $error("pass_all_multicast: expected %b, got %b",
                         want.pass_all_multicast, rsp_payload.pass_all_multicast);
                  failures++;
               end
               if (rsp_payload.promiscuous_on !== want.promiscuous_on) begin
                  $error("promiscuous_on: expected %b, got %b",
                         want.promiscuous_on, rsp_payload.promiscuous_on);
                  failures++;
               end
            end
         end

         if (req_valid && req_ready) begin
            // Unicast addresses still count toward the list limit.
            if (req_payload.carries_address) begin
               if (listed_count < MAX_HASHED_ADDRESSES + 1) begin
                  listed_count++;
               end
               if (req_payload.mac_address[0]) begin
                  filter_bits[filter_slot(req_payload.mac_address)] = 1'b1;
               end
            end
            if (req_payload.last_address) begin
               pass_all = promisc_mode | allmulti_mode |
                          (listed_count > MAX_HASHED_ADDRESSES);
               want.hash_low_word      =
                  pass_all ? '0 : filter_bits[mhfb_pkg::WORD_WIDTH-1:0];
               want.hash_high_word     =
                  pass_all ? '0 : filter_bits[mhfb_pkg::TABLE_WIDTH-1:mhfb_pkg::WORD_WIDTH];
               want.pass_all_multicast = pass_all;
               want.promiscuous_on     = promisc_mode;
               expected_reports.push_back(want);
               filter_bits  = '0;
               listed_count = 0;
            end
         end
      end
      reports_pending = expected_reports.size();
   end

endmodule

/* verif/multicast_hash_filter_builder_core_tb.sv */
// Testbench top for multicast_hash_filter_builder_core: drives address lists
// and mode settings, and gives the verdict from mhfb_report_checker.
// Depends on mhfb_pkg, mhfb_report_checker and the core.
module multicast_hash_filter_builder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIST_LIMIT   = 64;
   localparam int unsigned SETTLE_DELAY = 4;
   localparam int unsigned PHASE_ITEMS  = 240;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   mhfb_pkg::req_payload_type            req_payload;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   mhfb_pkg::rsp_payload_type            rsp_payload;
   logic                                 csr_write_enable;
   logic [mhfb_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [mhfb_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data;

   int unsigned failures;
   int unsigned reports_pending;
   int unsigned reports_checked;
   int unsigned requests_sent;
   int unsigned responses_taken;

   multicast_hash_filter_builder_core #(
      .MAX_HASHED_ADDRESSES(LIST_LIMIT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   mhfb_report_checker #(
      .MAX_HASHED_ADDRESSES(LIST_LIMIT)
   ) report_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .reports_pending  (reports_pending),
      .reports_checked  (reports_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d reports still pending", reports_pending);
      $display("Some tests failed");
      $finish;
   end

   // Sends one request, first holding valid low for the given gap. Returns at
   // the clock edge that accepts it.
   task automatic send_request(input logic [mhfb_pkg::MAC_WIDTH-1:0] mac,
                               input logic carries, input logic last_flag,
                               input int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{mac_address: mac, carries_address: carries, last_address: last_flag};
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      requests_sent++;
   endtask

   // Lets every pending report drain, then waits out the pipeline.
   task automatic drain_reports();
      req_valid <= 1'b0;
      do @(negedge clock); while (reports_pending != 0);
      repeat (SETTLE_DELAY) @(posedge clock);
   endtask

   task automatic write_modes(input logic promisc, input logic allmulti);
      csr_write_enable <= 1'b1;
      csr_index        <= mhfb_pkg::CSR_PROMISCUOUS_ENABLE;
      csr_write_data   <= promisc;
      @(posedge clock);
      csr_index        <= mhfb_pkg::CSR_ALL_MULTICAST_ENABLE;
      csr_write_data   <= allmulti;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random lists: mostly short, some around the 64-entry limit and a few long
   // enough to test that the address count saturates instead of wrapping.
   task automatic send_random_lists(input int unsigned budget);
      int unsigned                    sent;
      int unsigned                    length;
      int unsigned                    kind;
      logic                           back_to_back;
      logic                           carries;
      logic [mhfb_pkg::MAC_WIDTH-1:0] mac;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 31);
         if (kind < 4) begin
            length = $urandom_range(LIST_LIMIT - 4, LIST_LIMIT + 6);
         end else if (kind == 4) begin
            length = $urandom_range(2 * LIST_LIMIT - 2, 2 * LIST_LIMIT + 6);
         end else begin
            length = $urandom_range(1, 10);
         end
         back_to_back = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < length; i++) begin
            mac = {16'($urandom), 32'($urandom)};
            if ($urandom_range(0, 3) != 0) begin
               mac[0] = 1'b1;
            end
            carries = (length > 10) ? ($urandom_range(0, 39) != 0)
                                    : ($urandom_range(0, 9) != 0);
            send_request(mac, carries, i == length - 1,
                         back_to_back ? 0 : $urandom_range(0, 19));
            sent++;
         end
      end
   endtask

   // The receiver stalls a random number of cycles before each response, with
   // regular stretches where it never stalls.
   initial begin
      int unsigned stall;
      rsp_ready       <= 1'b0;
      responses_taken = 0;
      @(negedge reset);
      forever begin
         stall = (responses_taken % 24 < 6) ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!(rsp_valid && rsp_ready));
         @(posedge clock);
         responses_taken++;
      end
   end

   initial begin
      requests_sent    = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_payload      <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= mhfb_pkg::CSR_PROMISCUOUS_ENABLE;
      csr_write_data   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lists with both modes off.
      write_modes(1'b0, 1'b0);
      send_request(48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 0);   // empty list
      send_request(48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 0);
      send_request(48'h0000_0000_0001, 1'b1, 1'b1, 3);
      send_request(48'h0000_0000_0000, 1'b1, 1'b1, 0);   // unicast only
      send_request(48'hFFFF_FFFF_FFFE, 1'b1, 1'b0, 0);
      send_request(48'h0100_005E_0001, 1'b1, 1'b0, 0);
      send_request(48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 2);
      send_request(48'h5555_5555_5555, 1'b1, 1'b0, 0);
      send_request(48'h0100_0033_3333, 1'b1, 1'b1, 0);
      send_random_lists(PHASE_ITEMS);
      drain_reports();

      write_modes(1'b1, 1'b0);
      send_request(48'h0000_0000_0001, 1'b1, 1'b1, 0);
      send_request(48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 0);
      send_random_lists(PHASE_ITEMS);
      drain_reports();

      write_modes(1'b0, 1'b1);
      send_request(48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 0);
      send_random_lists(PHASE_ITEMS);
      drain_reports();

      write_modes(1'b1, 1'b1);
      send_random_lists(PHASE_ITEMS);
      drain_reports();

      write_modes(1'b0, 1'b0);
      send_random_lists(PHASE_ITEMS);
      drain_reports();
      @(negedge clock);

      $display("Sent %0d address requests across five mode settings.", requests_sent);
      $display("Compared %0d filter reports, including lists past the hash limit.",
               reports_checked);
      if (failures == 0 && reports_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
